>>> hw/rtl/rgvg_pkg.sv
// Types, constants and arithmetic helpers of the ripple grid vertex generator.
// Used by ripple_grid_vertex_generator_top; depends on nothing.
`default_nettype none

package rgvg_pkg;

	// 2^32 / (2*pi): radians in Q16.32 to turns in Q0.32
	localparam logic [29:0] TURN_SCALE = 30'd683565276;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam int CORDIC_STEPS = 20;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 16;
	localparam logic [15:0] UNIT_Q14 = 16'd16384;

	// atan(2^-i) in Q0.32 turns
	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
	};

	typedef enum logic [2:0] {
		REG_ORIGIN_X,
		REG_ORIGIN_Z,
		REG_STEP_X,
		REG_STEP_Z,
		REG_CENTER_X,
		REG_CENTER_Z,
		REG_WAVE_NUMBER,
		REG_AMPLITUDE
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]         col;
		logic [7:0]         row;
		logic signed [31:0] px;
		logic signed [31:0] pz;
	} vtx_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] root;
	} sq_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
	} cs_t;

	typedef struct packed {
		logic [46:0] rem;
		logic [15:0] quo;
	} dv_t;

	typedef struct packed {
		logic        neg_x;
		logic        neg_z;
		logic        zero;
	} nflag_t;

	// result beat, pos_x in the lowest bits
	typedef struct packed {
		logic [7:0]         tex_v;
		logic [7:0]         tex_u;
		logic signed [15:0] normal_z;
		logic [14:0]        normal_y;
		logic signed [15:0] normal_x;
		logic signed [31:0] pos_z;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_x;
	} res_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// one restoring square root step, two radicand bits
	function automatic sq_t sqrt_step(input sq_t s, input logic [63:0] bitv);
		logic [63:0] trial;
		sq_t r;
		trial = s.root + bitv;
		if (s.rem >= trial) begin
			r.rem = s.rem - trial;
			r.root = (s.root >> 1) + bitv;
		end else begin
			r.rem = s.rem;
			r.root = s.root >> 1;
		end
		return r;
	endfunction

	function automatic cs_t cordic_init(input logic [31:0] a);
		cs_t r;
		r.x = CORDIC_GAIN;
		r.y = '0;
		r.z = $signed({4'b0000, a[29:0]});
		return r;
	endfunction

	function automatic cs_t cordic_step(input cs_t s, input int i);
		logic signed [33:0] xs;
		logic signed [33:0] ys;
		logic signed [33:0] at;
		cs_t r;
		xs = s.x >>> i;
		ys = s.y >>> i;
		at = $signed({2'b00, ATAN_TURNS[i]});
		if (!s.z[33]) begin
			r.x = s.x - ys;
			r.y = s.y + xs;
			r.z = s.z - at;
		end else begin
			r.x = s.x + ys;
			r.y = s.y - xs;
			r.z = s.z + at;
		end
		return r;
	endfunction

	function automatic logic signed [33:0] quad_cos(input cs_t s, input logic [1:0] q);
		case (q)
			2'd0:    return s.x;
			2'd1:    return -s.y;
			2'd2:    return -s.x;
			default: return s.y;
		endcase
	endfunction

	function automatic logic signed [33:0] quad_sin(input cs_t s, input logic [1:0] q);
		case (q)
			2'd0:    return s.y;
			2'd1:    return s.x;
			2'd2:    return -s.y;
			default: return -s.x;
		endcase
	endfunction

	// one restoring division step for quotient bit j
	function automatic dv_t div_step(input dv_t s, input logic [30:0] n, input int j);
		logic [46:0] d;
		dv_t r;
		d = 47'(n) << j;
		r = s;
		if (s.rem >= d) begin
			r.rem = s.rem - d;
			r.quo = s.quo | (16'd1 << j);
		end
		return r;
	endfunction

	function automatic logic [15:0] unit_comp(input logic [15:0] q, input logic neg);
		logic [15:0] qc;
		qc = (q > UNIT_Q14) ? UNIT_Q14 : q;
		return neg ? (16'd0 - qc) : qc;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ripple_grid_vertex_generator_top.sv
// Ripple grid vertex generator: position, unit normal and texture coordinates per vertex.
// Depends on rgvg_pkg (types, CORDIC table, square root and division steps).
//
// Usage:
//   s_axis carries one vertex per beat: tdata = {row_index, col_index}. m_axis returns
//   one beat per vertex in the same order. Indices above MAX_BLOCKS are clamped.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data), written while idle.
// Throughput: one vertex per cycle while the output buffer has room. All work is a
//   fixed pipeline: two 32-step square roots, three parallel 20-step CORDICs and three
//   16-step dividers, one step per stage; 114 registered stages in all, followed by the
//   output buffer that presents each result at m_axis.
// Stall: the pipeline advances while a two-entry output buffer has room, so input is
//   still taken while one finished result waits; with both entries full, s_axis_tready
//   drops and the whole pipeline holds.
// Reset: arst_n clears all valid bits and the buffer and loads the register defaults.
`default_nettype none

module ripple_grid_vertex_generator_top #(
	parameter int MAX_BLOCKS = 128
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [15:0]  s_axis_tdata,   // col_index[7:0], row_index[15:8]
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// pos_x[31:0], pos_y[63:32], pos_z[95:64], normal_x[111:96], normal_y[126:112],
	// normal_z[142:127], tex_u[150:143], tex_v[158:151], zero pad[159]
	output logic [159:0]      m_axis_tdata,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	localparam int SQ = rgvg_pkg::SQRT_STEPS;
	localparam int CS = rgvg_pkg::CORDIC_STEPS;
	localparam int DS = rgvg_pkg::DIV_STEPS;
	localparam int NSTG = 6 + SQ + 3 + CS + 3 + SQ + 1 + DS + 1;
	localparam logic [7:0] MAX_IDX = 8'(MAX_BLOCKS);

	// configuration registers
	logic signed [31:0] origin_x_q, origin_z_q, center_x_q, center_z_q;
	logic [30:0]        step_x_q, step_z_q, amplitude_q;
	logic [15:0]        wave_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= '0;
			origin_z_q  <= '0;
			step_x_q    <= 31'd65536;
			step_z_q    <= 31'd65536;
			center_x_q  <= 32'sd6553600;
			center_z_q  <= 32'sd6553600;
			wave_q      <= 16'd1311;
			amplitude_q <= 31'd1966080;
		end else if (cfg_we) begin
			unique case (rgvg_pkg::reg_idx_t'(cfg_index))
				rgvg_pkg::REG_ORIGIN_X:    origin_x_q  <= cfg_data;
				rgvg_pkg::REG_ORIGIN_Z:    origin_z_q  <= cfg_data;
				rgvg_pkg::REG_STEP_X:      step_x_q    <= cfg_data[30:0];
				rgvg_pkg::REG_STEP_Z:      step_z_q    <= cfg_data[30:0];
				rgvg_pkg::REG_CENTER_X:    center_x_q  <= cfg_data;
				rgvg_pkg::REG_CENTER_Z:    center_z_q  <= cfg_data;
				rgvg_pkg::REG_WAVE_NUMBER: wave_q      <= cfg_data[15:0];
				rgvg_pkg::REG_AMPLITUDE:   amplitude_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// pipeline enable and valid bits
	logic [1:0]      cnt_q;
	logic            ce, acc, push, pop;
	logic [NSTG-1:0] vld_q;

	assign ce = (cnt_q != 2'd2);
	assign s_axis_tready = ce;
	assign acc = s_axis_tvalid & ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ce) begin
			vld_q <= {vld_q[NSTG-2:0], acc};
		end
	end

	// stage 1: clamp indices, index times step
	logic [7:0]  col_c, row_c;
	logic [7:0]  col_s1, row_s1;
	logic [38:0] prodx_s1, prodz_s1;

	assign col_c = (s_axis_tdata[7:0] > MAX_IDX) ? MAX_IDX : s_axis_tdata[7:0];
	assign row_c = (s_axis_tdata[15:8] > MAX_IDX) ? MAX_IDX : s_axis_tdata[15:8];

	always_ff @(posedge clk) begin
		if (ce) begin
			col_s1   <= col_c;
			row_s1   <= row_c;
			prodx_s1 <= 39'(col_c) * 39'(step_x_q);
			prodz_s1 <= 39'(row_c) * 39'(step_z_q);
		end
	end

	// stage 2: saturated positions
	logic signed [40:0] sumx, sumz;
	logic [7:0]         col_s2, row_s2;
	logic signed [31:0] px_s2, pz_s2;

	assign sumx = 41'(origin_x_q) + 41'($signed({1'b0, prodx_s1}));
	assign sumz = 41'(origin_z_q) - 41'($signed({1'b0, prodz_s1}));

	always_ff @(posedge clk) begin
		if (ce) begin
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			px_s2  <= rgvg_pkg::sat32(64'(sumx));
			pz_s2  <= rgvg_pkg::sat32(64'(sumz));
		end
	end

	// stage 3: saturated offsets from the ripple center
	rgvg_pkg::vtx_t     vtx_s3;
	logic signed [31:0] dx_s3, dz_s3;

	always_ff @(posedge clk) begin
		if (ce) begin
			vtx_s3 <= '{col: col_s2, row: row_s2, px: px_s2, pz: pz_s2};
			dx_s3  <= rgvg_pkg::sat32(64'(px_s2) - 64'(center_x_q));
			dz_s3  <= rgvg_pkg::sat32(64'(pz_s2) - 64'(center_z_q));
		end
	end

	// stage 4: squares and offset phases
	rgvg_pkg::vtx_t     vtx_s4;
	logic signed [63:0] sqx_s4, sqz_s4, pkx_s4, pkz_s4;
	logic signed [16:0] wave_s;

	assign wave_s = $signed({1'b0, wave_q});

	always_ff @(posedge clk) begin
		if (ce) begin
			vtx_s4 <= vtx_s3;
			sqx_s4 <= 64'(dx_s3) * 64'(dx_s3);
			sqz_s4 <= 64'(dz_s3) * 64'(dz_s3);
			pkx_s4 <= 64'(dx_s3) * 64'(wave_s);
			pkz_s4 <= 64'(dz_s3) * 64'(wave_s);
		end
	end

	// stage 5: sum of squares, turn conversion partial products
	rgvg_pkg::vtx_t vtx_s5;
	logic [63:0]    sum_s5;
	logic [61:0]    plx_s5, plz_s5;
	logic [31:0]    phx_s5, phz_s5;

	always_ff @(posedge clk) begin
		if (ce) begin
			vtx_s5 <= vtx_s4;
			sum_s5 <= sqx_s4 + sqz_s4;
			plx_s5 <= 62'(pkx_s4[31:0]) * 62'(rgvg_pkg::TURN_SCALE);
			plz_s5 <= 62'(pkz_s4[31:0]) * 62'(rgvg_pkg::TURN_SCALE);
			phx_s5 <= pkx_s4[63:32] * 32'(rgvg_pkg::TURN_SCALE);
			phz_s5 <= pkz_s4[63:32] * 32'(rgvg_pkg::TURN_SCALE);
		end
	end

	// stage 6: offset phases in turns
	rgvg_pkg::vtx_t vtx_s6;
	logic [63:0]    sum_s6;
	logic [31:0]    tx_s6, tz_s6;

	always_ff @(posedge clk) begin
		if (ce) begin
			vtx_s6 <= vtx_s5;
			sum_s6 <= sum_s5;
			tx_s6  <= phx_s5 + 32'(plx_s5[61:32]);
			tz_s6  <= phz_s5 + 32'(plz_s5[61:32]);
		end
	end

	// distance square root, one root bit per stage
	rgvg_pkg::sq_t  lsq_s [SQ];
	rgvg_pkg::vtx_t lvx_s [SQ];
	logic [31:0]    ltx_s [SQ];
	logic [31:0]    ltz_s [SQ];

	for (genvar g = 0; g < SQ; g++) begin : g_lsqrt
		rgvg_pkg::sq_t  sq_in;
		rgvg_pkg::vtx_t vx_in;
		logic [31:0]    tx_in, tz_in;
		if (g == 0) begin : g_first
			assign sq_in = '{rem: sum_s6, root: 64'd0};
			assign vx_in = vtx_s6;
			assign tx_in = tx_s6;
			assign tz_in = tz_s6;
		end else begin : g_next
			assign sq_in = lsq_s[g-1];
			assign vx_in = lvx_s[g-1];
			assign tx_in = ltx_s[g-1];
			assign tz_in = ltz_s[g-1];
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				lsq_s[g] <= rgvg_pkg::sqrt_step(sq_in, 64'd1 << (62 - 2 * g));
				lvx_s[g] <= vx_in;
				ltx_s[g] <= tx_in;
				ltz_s[g] <= tz_in;
			end
		end
	end

	// stages B1 to B3: distance phase in turns
	rgvg_pkg::vtx_t vtx_b1, vtx_b2, vtx_b3;
	logic [31:0]    tx_b1, tz_b1, tx_b2, tz_b2, tx_b3, tz_b3;
	logic [47:0]    lk_b1;
	logic [61:0]    pll_b2;
	logic [31:0]    phl_b2, tl_b3;

	always_ff @(posedge clk) begin
		if (ce) begin
			vtx_b1 <= lvx_s[SQ-1];
			tx_b1  <= ltx_s[SQ-1];
			tz_b1  <= ltz_s[SQ-1];
			lk_b1  <= 48'(lsq_s[SQ-1].root[31:0]) * 48'(wave_q);
			vtx_b2 <= vtx_b1;
			tx_b2  <= tx_b1;
			tz_b2  <= tz_b1;
			pll_b2 <= 62'(lk_b1[31:0]) * 62'(rgvg_pkg::TURN_SCALE);
			phl_b2 <= 32'(lk_b1[47:32]) * 32'(rgvg_pkg::TURN_SCALE);
			vtx_b3 <= vtx_b2;
			tx_b3  <= tx_b2;
			tz_b3  <= tz_b2;
			tl_b3  <= phl_b2 + 32'(pll_b2[61:32]);
		end
	end

	// three CORDICs side by side, one rotation per stage
	rgvg_pkg::cs_t  crl_c [CS];
	rgvg_pkg::cs_t  crx_c [CS];
	rgvg_pkg::cs_t  crz_c [CS];
	logic [5:0]     quad_c [CS];
	rgvg_pkg::vtx_t vtx_c [CS];

	for (genvar g = 0; g < CS; g++) begin : g_cordic
		rgvg_pkg::cs_t  l_in, x_in, z_in;
		logic [5:0]     q_in;
		rgvg_pkg::vtx_t vx_in;
		if (g == 0) begin : g_first
			assign l_in  = rgvg_pkg::cordic_init(tl_b3);
			assign x_in  = rgvg_pkg::cordic_init(tx_b3);
			assign z_in  = rgvg_pkg::cordic_init(tz_b3);
			assign q_in  = {tl_b3[31:30], tx_b3[31:30], tz_b3[31:30]};
			assign vx_in = vtx_b3;
		end else begin : g_next
			assign l_in  = crl_c[g-1];
			assign x_in  = crx_c[g-1];
			assign z_in  = crz_c[g-1];
			assign q_in  = quad_c[g-1];
			assign vx_in = vtx_c[g-1];
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				crl_c[g]  <= rgvg_pkg::cordic_step(l_in, g);
				crx_c[g]  <= rgvg_pkg::cordic_step(x_in, g);
				crz_c[g]  <= rgvg_pkg::cordic_step(z_in, g);
				quad_c[g] <= q_in;
				vtx_c[g]  <= vx_in;
			end
		end
	end

	// stage D1: map quadrants
	rgvg_pkg::vtx_t     vtx_d1;
	logic signed [33:0] cl_d1, sx_d1, sz_d1;

	always_ff @(posedge clk) begin
		if (ce) begin
			vtx_d1 <= vtx_c[CS-1];
			cl_d1  <= rgvg_pkg::quad_cos(crl_c[CS-1], quad_c[CS-1][5:4]);
			sx_d1  <= rgvg_pkg::quad_sin(crx_c[CS-1], quad_c[CS-1][3:2]);
			sz_d1  <= rgvg_pkg::quad_sin(crz_c[CS-1], quad_c[CS-1][1:0]);
		end
	end

	// stage D2: height product, normal squares
	rgvg_pkg::vtx_t     vtx_d2;
	logic signed [65:0] ampcl_d2;
	logic signed [63:0] sqsx_d2, sqny_d2, sqsz_d2;
	logic signed [33:0] sx_d2, ny_d2, sz_d2, ny_abs;
	logic signed [31:0] amp_s;

	assign ny_abs = cl_d1[33] ? -cl_d1 : cl_d1;
	assign amp_s = $signed({1'b0, amplitude_q});

	always_ff @(posedge clk) begin
		if (ce) begin
			vtx_d2   <= vtx_d1;
			ampcl_d2 <= 66'(amp_s) * 66'(cl_d1);
			sqsx_d2  <= 64'(sx_d1) * 64'(sx_d1);
			sqny_d2  <= 64'(ny_abs) * 64'(ny_abs);
			sqsz_d2  <= 64'(sz_d1) * 64'(sz_d1);
			sx_d2    <= sx_d1;
			ny_d2    <= ny_abs;
			sz_d2    <= sz_d1;
		end
	end

	// stage D3: saturated height, normal length squared
	rgvg_pkg::vtx_t     vtx_d3;
	logic signed [31:0] py_d3;
	logic [63:0]        nsum_d3;
	logic signed [33:0] sx_d3, ny_d3, sz_d3;
	logic signed [65:0] ampcl_sh;

	assign ampcl_sh = ampcl_d2 >>> 30;

	always_ff @(posedge clk) begin
		if (ce) begin
			vtx_d3  <= vtx_d2;
			py_d3   <= rgvg_pkg::sat32(ampcl_sh[63:0]);
			nsum_d3 <= sqsx_d2 + sqny_d2 + sqsz_d2;
			sx_d3   <= sx_d2;
			ny_d3   <= ny_d2;
			sz_d3   <= sz_d2;
		end
	end

	// normal length square root
	rgvg_pkg::sq_t      nsq_s [SQ];
	rgvg_pkg::vtx_t     nvx_s [SQ];
	logic signed [31:0] npy_s [SQ];
	logic signed [33:0] nsx_s [SQ];
	logic signed [33:0] nny_s [SQ];
	logic signed [33:0] nsz_s [SQ];

	for (genvar g = 0; g < SQ; g++) begin : g_nsqrt
		rgvg_pkg::sq_t      sq_in;
		rgvg_pkg::vtx_t     vx_in;
		logic signed [31:0] py_in;
		logic signed [33:0] sx_in, ny_in, sz_in;
		if (g == 0) begin : g_first
			assign sq_in = '{rem: nsum_d3, root: 64'd0};
			assign vx_in = vtx_d3;
			assign py_in = py_d3;
			assign sx_in = sx_d3;
			assign ny_in = ny_d3;
			assign sz_in = sz_d3;
		end else begin : g_next
			assign sq_in = nsq_s[g-1];
			assign vx_in = nvx_s[g-1];
			assign py_in = npy_s[g-1];
			assign sx_in = nsx_s[g-1];
			assign ny_in = nny_s[g-1];
			assign sz_in = nsz_s[g-1];
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				nsq_s[g] <= rgvg_pkg::sqrt_step(sq_in, 64'd1 << (62 - 2 * g));
				nvx_s[g] <= vx_in;
				npy_s[g] <= py_in;
				nsx_s[g] <= sx_in;
				nny_s[g] <= ny_in;
				nsz_s[g] <= sz_in;
			end
		end
	end

	// stage E1: rounded numerators for the three divisions
	logic [30:0]        nrm;
	logic [32:0]        mx, my, mz;
	rgvg_pkg::vtx_t     vtx_e1;
	logic signed [31:0] py_e1;
	logic [30:0]        n_e1;
	rgvg_pkg::dv_t      dvx_e1, dvy_e1, dvz_e1;
	rgvg_pkg::nflag_t   fl_e1;

	assign nrm = nsq_s[SQ-1].root[30:0];
	assign mx = nsx_s[SQ-1][33] ? 33'(-nsx_s[SQ-1]) : nsx_s[SQ-1][32:0];
	assign my = nny_s[SQ-1][32:0];
	assign mz = nsz_s[SQ-1][33] ? 33'(-nsz_s[SQ-1]) : nsz_s[SQ-1][32:0];

	always_ff @(posedge clk) begin
		if (ce) begin
			vtx_e1 <= nvx_s[SQ-1];
			py_e1  <= npy_s[SQ-1];
			n_e1   <= nrm;
			dvx_e1 <= '{rem: (47'(mx) << 14) + 47'(nrm >> 1), quo: 16'd0};
			dvy_e1 <= '{rem: (47'(my) << 14) + 47'(nrm >> 1), quo: 16'd0};
			dvz_e1 <= '{rem: (47'(mz) << 14) + 47'(nrm >> 1), quo: 16'd0};
			fl_e1  <= '{neg_x: nsx_s[SQ-1][33], neg_z: nsz_s[SQ-1][33], zero: (nrm == '0)};
		end
	end

	// three dividers, one quotient bit per stage
	rgvg_pkg::dv_t      dvx_v [DS];
	rgvg_pkg::dv_t      dvy_v [DS];
	rgvg_pkg::dv_t      dvz_v [DS];
	logic [30:0]        n_v   [DS];
	rgvg_pkg::nflag_t   fl_v  [DS];
	rgvg_pkg::vtx_t     vtx_v [DS];
	logic signed [31:0] py_v  [DS];

	for (genvar g = 0; g < DS; g++) begin : g_div
		rgvg_pkg::dv_t      x_in, y_in, z_in;
		logic [30:0]        n_in;
		rgvg_pkg::nflag_t   f_in;
		rgvg_pkg::vtx_t     vx_in;
		logic signed [31:0] py_in;
		if (g == 0) begin : g_first
			assign x_in  = dvx_e1;
			assign y_in  = dvy_e1;
			assign z_in  = dvz_e1;
			assign n_in  = n_e1;
			assign f_in  = fl_e1;
			assign vx_in = vtx_e1;
			assign py_in = py_e1;
		end else begin : g_next
			assign x_in  = dvx_v[g-1];
			assign y_in  = dvy_v[g-1];
			assign z_in  = dvz_v[g-1];
			assign n_in  = n_v[g-1];
			assign f_in  = fl_v[g-1];
			assign vx_in = vtx_v[g-1];
			assign py_in = py_v[g-1];
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				dvx_v[g] <= rgvg_pkg::div_step(x_in, n_in, DS - 1 - g);
				dvy_v[g] <= rgvg_pkg::div_step(y_in, n_in, DS - 1 - g);
				dvz_v[g] <= rgvg_pkg::div_step(z_in, n_in, DS - 1 - g);
				n_v[g]   <= n_in;
				fl_v[g]  <= f_in;
				vtx_v[g] <= vx_in;
				py_v[g]  <= py_in;
			end
		end
	end

	// stage F1: clamp, sign and assemble; a zero-length normal points straight up
	rgvg_pkg::res_t   res_f1;
	rgvg_pkg::nflag_t fl_last;
	logic [15:0]      nx_u, ny_u, nz_u;

	assign fl_last = fl_v[DS-1];
	assign nx_u = rgvg_pkg::unit_comp(dvx_v[DS-1].quo, fl_last.neg_x);
	assign ny_u = rgvg_pkg::unit_comp(dvy_v[DS-1].quo, 1'b0);
	assign nz_u = rgvg_pkg::unit_comp(dvz_v[DS-1].quo, fl_last.neg_z);

	always_ff @(posedge clk) begin
		if (ce) begin
			res_f1.pos_x    <= vtx_v[DS-1].px;
			res_f1.pos_y    <= py_v[DS-1];
			res_f1.pos_z    <= vtx_v[DS-1].pz;
			res_f1.normal_x <= fl_last.zero ? 16'sd0 : $signed(nx_u);
			res_f1.normal_y <= fl_last.zero ? rgvg_pkg::UNIT_Q14[14:0] : ny_u[14:0];
			res_f1.normal_z <= fl_last.zero ? 16'sd0 : $signed(nz_u);
			res_f1.tex_u    <= vtx_v[DS-1].col;
			res_f1.tex_v    <= vtx_v[DS-1].row;
		end
	end

	// two-entry output buffer, head in entry zero
	rgvg_pkg::res_t buf_q [2];
	logic [1:0]     wr_sum;
	logic           wr_idx;

	assign push = ce & vld_q[NSTG-1];
	assign pop = m_axis_tvalid & m_axis_tready;
	assign wr_sum = cnt_q - {1'b0, pop};
	assign wr_idx = wr_sum[0];

	// load the head from the pipeline or shift the second entry forward
	always_ff @(posedge clk) begin
		if (push && !wr_idx) begin
			buf_q[0] <= res_f1;
		end else if (pop) begin
			buf_q[0] <= buf_q[1];
		end
		if (push && wr_idx) begin
			buf_q[1] <= res_f1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata = {1'b0, buf_q[0]};

	// buffer never overfills
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("output buffer count out of range");

	// a full buffer freezes the pipeline and the input
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> (!s_axis_tready && !push))
		else $error("pipeline advanced into a full buffer");

	// a taken beat from a full buffer leaves the second result on the port
	a_second_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cnt_q == 2'd2) |=> m_axis_tvalid)
		else $error("second buffered result lost");

	// a result pushed into an empty buffer shows up on the next cycle
	a_push_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cnt_q == 2'd0) |=> (m_axis_tvalid && m_axis_tdata[158:0] == $past(res_f1)))
		else $error("pushed result not presented");

endmodule

`default_nettype wire
